### rtl/core/hidkb_pkg.sv
// Shared types, constants and helpers for the HID boot keyboard report builder.
// No dependencies; imported by every module of the block.
package hidkb_pkg;

    localparam int KEY_W             = 8;
    localparam int MOD_W             = 8;
    localparam int MOD_IDX_W         = 3;
    localparam int OUT_SLOTS         = 6;
    localparam int NUM_KEY_SLOTS_DEF = 6;

    localparam logic [KEY_W-1:0] MOD_FIRST = 8'hE0;
    localparam logic [KEY_W-1:0] MOD_END   = 8'hE8;
    localparam logic [KEY_W-1:0] KEY_NONE  = 8'h00;

    typedef enum logic [1:0] {
        FUNC_PRESS       = 2'd0,
        FUNC_RELEASE     = 2'd1,
        FUNC_RELEASE_ALL = 2'd2
    } func_t;

    typedef struct packed {
        func_t            func;
        logic [KEY_W-1:0] key;
    } hidkb_cmd_t;

    function automatic logic is_modifier(input logic [KEY_W-1:0] code);
        return (code >= MOD_FIRST) && (code < MOD_END);
    endfunction

endpackage

### rtl/core/hid_keyboard_report_builder_core.sv
// Top level of the HID boot keyboard report builder: input register, report state.
// Depends on hidkb_pkg and hidkb_slot_update.
//
// Each accepted transaction (press, release or release-all of one usage code) yields one
// report transaction with the updated modifier byte and six key slots, newest first.
// An accepted transaction is first captured in the input register, then the slot
// compare/compact logic writes the report registers, which also drive the output.
// One transaction is accepted per cycle while the report side keeps up;
// the report registers double as the output stage, so a stalled report holds the input
// register, and both stall together.
module hid_keyboard_report_builder_core #(
    parameter int NUM_KEY_SLOTS = hidkb_pkg::NUM_KEY_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [hidkb_pkg::KEY_W-1:0] key,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hidkb_pkg::MOD_W-1:0] modifier_bits,
    output logic [hidkb_pkg::KEY_W-1:0] slot_0,
    output logic [hidkb_pkg::KEY_W-1:0] slot_1,
    output logic [hidkb_pkg::KEY_W-1:0] slot_2,
    output logic [hidkb_pkg::KEY_W-1:0] slot_3,
    output logic [hidkb_pkg::KEY_W-1:0] slot_4,
    output logic [hidkb_pkg::KEY_W-1:0] slot_5
);
    import hidkb_pkg::*;

    logic                                  cmd_valid_reg;
    hidkb_cmd_t                            cmd_reg;
    logic                                  out_valid_reg;
    logic [MOD_W-1:0]                      modifier_reg;
    logic [MOD_W-1:0]                      modifier_next;
    logic [NUM_KEY_SLOTS-1:0][KEY_W-1:0]   slot_reg;
    logic [NUM_KEY_SLOTS-1:0][KEY_W-1:0]   slot_next;
    logic [OUT_SLOTS-1:0][KEY_W-1:0]       slot_out;
    logic [MOD_W-1:0]                      mod_mask;
    logic                                  report_free;
    logic                                  advance;

    assign report_free = !out_valid_reg || out_ready;
    assign advance     = cmd_valid_reg && report_free;
    assign in_ready    = !cmd_valid_reg || report_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            cmd_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg.func <= func_t'(func);
            cmd_reg.key  <= key;
        end
    end

    hidkb_slot_update #(
        .NUM_SLOTS (NUM_KEY_SLOTS)
    ) u_slot_update (
        .cmd        (cmd_reg),
        .slots      (slot_reg),
        .slots_next (slot_next)
    );

    assign mod_mask = MOD_W'(1) << MOD_IDX_W'(cmd_reg.key - MOD_FIRST);

    always_comb
    begin
        modifier_next = modifier_reg;
        case (cmd_reg.func)
            FUNC_PRESS:
            begin
                if (is_modifier(cmd_reg.key))
                begin
                    modifier_next = modifier_reg | mod_mask;
                end
            end
            FUNC_RELEASE:
            begin
                if (is_modifier(cmd_reg.key))
                begin
                    modifier_next = modifier_reg & ~mod_mask;
                end
            end
            default:
            begin
                modifier_next = modifier_reg;
            end
        endcase
    end

    // report state, also the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            modifier_reg  <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            if (report_free)
            begin
                out_valid_reg <= cmd_valid_reg;
            end
            if (advance)
            begin
                modifier_reg <= modifier_next;
                slot_reg     <= slot_next;
            end
        end
    end

    for (genvar j = 0; j < OUT_SLOTS; j++)
    begin : g_out
        if (j < NUM_KEY_SLOTS)
        begin : g_used
            assign slot_out[j] = slot_reg[j];
        end
        else
        begin : g_empty
            assign slot_out[j] = '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign modifier_bits = modifier_reg;
    assign slot_0        = slot_out[0];
    assign slot_1        = slot_out[1];
    assign slot_2        = slot_out[2];
    assign slot_3        = slot_out[3];
    assign slot_4        = slot_out[4];
    assign slot_5        = slot_out[5];

    a_release_all_keeps_mods: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && (cmd_reg.func == FUNC_RELEASE_ALL)
        |=> (slot_reg[0] == '0) && (modifier_reg == $past(modifier_reg))
    ) else $error("release-all must clear slots and keep modifiers");

    a_press_lands_first: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && (cmd_reg.func == FUNC_PRESS) && (cmd_reg.key != KEY_NONE)
            && !is_modifier(cmd_reg.key)
        |=> (slot_reg[0] == $past(cmd_reg.key)) && (modifier_reg == $past(modifier_reg))
    ) else $error("pressed key must land in the newest slot");

    a_no_modifier_in_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        !is_modifier(slot_reg[0])
    ) else $error("modifier code found in a key slot");

    a_state_only_on_advance: assert property (
        @(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(modifier_reg) && $stable(slot_reg)
    ) else $error("report state changed without a transaction");

endmodule

### rtl/core/hidkb_slot_update.sv
// Next-state logic for the key slots: drop matching codes, compact, push newest.
// Depends on hidkb_pkg.
module hidkb_slot_update #(
    parameter int NUM_SLOTS = hidkb_pkg::NUM_KEY_SLOTS_DEF
) (
    input  hidkb_pkg::hidkb_cmd_t                        cmd,
    input  logic [NUM_SLOTS-1:0][hidkb_pkg::KEY_W-1:0]   slots,
    output logic [NUM_SLOTS-1:0][hidkb_pkg::KEY_W-1:0]   slots_next
);
    import hidkb_pkg::*;

    localparam int POS_W = $clog2(NUM_SLOTS + 1);

    logic [NUM_SLOTS-1:0]                keep;
    logic [NUM_SLOTS-1:0][POS_W-1:0]     pos;
    logic [NUM_SLOTS-1:0][KEY_W-1:0]     kept;
    logic [NUM_SLOTS-1:0][KEY_W-1:0]     shifted;
    logic                                is_key;

    assign is_key = (cmd.key != KEY_NONE) && !is_modifier(cmd.key);

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            keep[i] = (slots[i] != cmd.key);
        end
        pos[0] = '0;
        for (int i = 1; i < NUM_SLOTS; i++)
        begin
            pos[i] = pos[i-1] + POS_W'(keep[i-1]);
        end
    end

    // compact surviving slots toward slot 0, zero-fill the tail
    always_comb
    begin
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            kept[j] = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (keep[i] && (pos[i] == POS_W'(j)))
                begin
                    kept[j] = kept[j] | slots[i];
                end
            end
        end
    end

    always_comb
    begin
        shifted[0] = cmd.key;
        for (int i = 1; i < NUM_SLOTS; i++)
        begin
            shifted[i] = kept[i-1];
        end
    end

    always_comb
    begin
        case (cmd.func)
            FUNC_PRESS:
            begin
                slots_next = is_key ? shifted : slots;
            end
            FUNC_RELEASE:
            begin
                slots_next = (cmd.key != KEY_NONE) ? kept : slots;
            end
            FUNC_RELEASE_ALL:
            begin
                slots_next = '0;
            end
            default:
            begin
                slots_next = slots;
            end
        endcase
    end

endmodule
